FILE: src/snnu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snnu_pkg
// Shared types and constants of the SOM node neighborhood update block.
// ----------------------------------------------------------------------------
package snnu_pkg;

    localparam int FEATURE_LEN = 256;
    localparam int MAP_SIDE    = 32;

    localparam int IDX_W   = 8;
    localparam int DATA_W  = 32;
    localparam int DEPTH   = (FEATURE_LEN < (2 ** IDX_W)) ? FEATURE_LEN : (2 ** IDX_W);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int RATE_HW = 20;
    localparam int MAG_W   = DATA_W + 1;
    localparam int PROD_W  = MAG_W + RATE_HW;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TRAIN = 2'd1,
        CMD_READ  = 2'd2
    } snnu_cmd_t;

    // learning rate, scaled by 2^40; one and none are flagged apart
    typedef struct packed {
        logic               none;
        logic               one;
        logic [RATE_HW-1:0] hi;
        logic [RATE_HW-1:0] lo;
    } snnu_rate_t;

    typedef struct packed {
        logic ok;
        logic load;
        logic train;
        logic wr;
        logic none;
        logic one;
    } snnu_ctl_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } snnu_wr_t;

endpackage
`default_nettype wire

FILE: src/snnu_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snnu_sched
// Manhattan distance to the winner and piecewise learning rate schedule.
// ----------------------------------------------------------------------------
module snnu_sched (
    input  wire logic [31:0]          iteration_count,
    input  wire logic [7:0]           winner_x,
    input  wire logic [7:0]           winner_y,
    input  wire logic [7:0]           node_x,
    input  wire logic [7:0]           node_y,
    output snnu_pkg::snnu_rate_t      rate
);
    import snnu_pkg::*;

    localparam logic [11:0] H1    = 12'(MAP_SIDE);
    localparam logic [11:0] H2    = 12'(2 * MAP_SIDE);
    localparam logic [11:0] H3    = 12'(3 * MAP_SIDE);
    localparam logic [11:0] H_D2  = 12'(MAP_SIDE / 2);
    localparam logic [11:0] H_D3  = 12'(MAP_SIDE / 3);
    localparam logic [11:0] H_D4  = 12'(MAP_SIDE / 4);
    localparam logic [11:0] H_D5  = 12'(MAP_SIDE / 5);
    localparam logic [11:0] H_D6  = 12'(MAP_SIDE / 6);
    localparam logic [11:0] H_D7  = 12'(MAP_SIDE / 7);

    localparam logic [39:0] R_5EM1  = 40'd549755813888;
    localparam logic [39:0] R_1EM1  = 40'd109951162777;
    localparam logic [39:0] R_5EM2  = 40'd54975581388;
    localparam logic [39:0] R_1EM2  = 40'd10995116277;
    localparam logic [39:0] R_5EM3  = 40'd5497558138;
    localparam logic [39:0] R_1EM3  = 40'd1099511627;
    localparam logic [39:0] R_5EM4  = 40'd549755813;
    localparam logic [39:0] R_1EM4  = 40'd109951162;
    localparam logic [39:0] R_1EM5  = 40'd10995116;
    localparam logic [39:0] R_5EM6  = 40'd5497558;
    localparam logic [39:0] R_3EM6  = 40'd3298534;
    localparam logic [39:0] R_1EM6  = 40'd1099511;
    localparam logic [39:0] R_5EM7  = 40'd549755;
    localparam logic [39:0] R_1EM7  = 40'd109951;
    localparam logic [39:0] R_5EM8  = 40'd54975;
    localparam logic [39:0] R_1EM8  = 40'd10995;
    localparam logic [39:0] R_1EM9  = 40'd1099;
    localparam logic [39:0] R_5EM10 = 40'd549;

    localparam logic [31:0] CNT_1K   = 32'd1000;
    localparam logic [31:0] CNT_100K = 32'd100000;
    localparam logic [31:0] CNT_1M   = 32'd1000000;
    localparam logic [31:0] CNT_1M5  = 32'd1500000;
    localparam logic [31:0] CNT_2M   = 32'd2000000;
    localparam logic [31:0] CNT_2M5  = 32'd2500000;
    localparam logic [31:0] CNT_3M   = 32'd3000000;
    localparam logic [31:0] CNT_4M   = 32'd4000000;
    localparam logic [31:0] CNT_5M   = 32'd5000000;
    localparam logic [31:0] CNT_10M  = 32'd10000000;
    localparam logic [31:0] CNT_100M = 32'd100000000;

    logic [8:0]  dx;
    logic [8:0]  dy;
    logic [7:0]  adx;
    logic [7:0]  ady;
    logic [11:0] mdist;
    logic [11:0] dist2;
    logic [11:0] dist3;
    logic [39:0] r;
    logic        one;

    always_comb begin
        dx    = {1'b0, node_x} - {1'b0, winner_x};
        dy    = {1'b0, node_y} - {1'b0, winner_y};
        adx   = dx[8] ? 8'(-dx) : dx[7:0];
        ady   = dy[8] ? 8'(-dy) : dy[7:0];
        mdist = 12'(adx) + 12'(ady);
        dist2 = mdist << 1;
        dist3 = dist2 + mdist;
        one   = 1'b0;
        r     = '0;
        if (iteration_count < CNT_5M) begin
            if (iteration_count <= CNT_1K && dist2 < H3) begin
                one = 1'b1;
            end else if (iteration_count <= CNT_100K && mdist < H1) begin
                r = R_5EM1;
            end else if (iteration_count <= CNT_1M && dist3 < H2) begin
                r = R_1EM1;
            end else if (iteration_count <= CNT_1M5 && mdist < H_D2) begin
                r = R_5EM2;
            end else if (iteration_count <= CNT_2M && mdist < H_D3) begin
                r = R_1EM2;
            end else if (iteration_count <= CNT_2M5 && mdist < H_D4) begin
                r = R_5EM3;
            end else if (iteration_count <= CNT_3M && mdist < H_D5) begin
                r = R_1EM3;
            end else if (iteration_count <= CNT_4M && mdist < H_D6) begin
                r = R_5EM4;
            end else if (mdist < H_D7) begin
                r = R_1EM4;
            end
        end else if (iteration_count < CNT_10M) begin
            case (mdist)
                12'd0, 12'd1, 12'd2, 12'd3: r = R_1EM5;
                12'd4:   r = R_5EM6;
                12'd5:   r = R_3EM6;
                12'd6:   r = R_1EM6;
                12'd7:   r = R_5EM7;
                12'd8:   r = R_1EM7;
                default: r = '0;
            endcase
        end else if (iteration_count < CNT_100M) begin
            case (mdist)
                12'd0:   r = R_1EM7;
                12'd1:   r = R_5EM8;
                12'd2:   r = R_1EM8;
                default: r = '0;
            endcase
        end else begin
            case (mdist)
                12'd0:   r = R_1EM9;
                12'd1:   r = R_5EM10;
                default: r = '0;
            endcase
        end
        rate.one  = one;
        rate.none = !one && (r == '0);
        rate.hi   = r[39:20];
        rate.lo   = r[19:0];
    end

endmodule
`default_nettype wire

FILE: src/snnu_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snnu_store
// Feature vector memory with registered read and last-write bypass.
// ----------------------------------------------------------------------------
module snnu_store (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rd_en,
    input  wire logic [snnu_pkg::IDX_W-1:0]    rd_idx,
    input  wire snnu_pkg::snnu_wr_t            wr,
    input  wire logic [snnu_pkg::IDX_W-1:0]    chk_idx,
    output logic      [snnu_pkg::DATA_W-1:0]   cur
);
    import snnu_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              byp_vld_reg;
    logic [IDX_W-1:0]  byp_idx_reg;
    logic [DATA_W-1:0] byp_val_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx[ADDR_W-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx[ADDR_W-1:0]];
        end
    end

    // most recent write equals the memory content of its index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_vld_reg <= 1'b0;
        end else if (wr.en) begin
            byp_vld_reg <= 1'b1;
        end
        if (wr.en) begin
            byp_idx_reg <= wr.idx;
            byp_val_reg <= wr.data;
        end
    end

    assign cur = (byp_vld_reg && byp_idx_reg == chk_idx) ? byp_val_reg : rd_data_reg;

endmodule
`default_nettype wire

FILE: src/snnu_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snnu_update
// Final element value selection and change flag.
// ----------------------------------------------------------------------------
module snnu_update (
    input  wire snnu_pkg::snnu_ctl_t           ctl,
    input  wire logic                          neg,
    input  wire logic [snnu_pkg::DATA_W-1:0]   cur,
    input  wire logic [snnu_pkg::DATA_W-1:0]   sample,
    input  wire logic [snnu_pkg::MAG_W-1:0]    delta,
    output logic      [snnu_pkg::DATA_W-1:0]   value,
    output logic                               upd
);
    import snnu_pkg::*;

    logic [DATA_W+1:0] cur_ext;
    logic [DATA_W+1:0] moved;
    logic [DATA_W-1:0] trained;

    always_comb begin
        cur_ext = {{2{cur[DATA_W-1]}}, cur};
        moved   = neg ? (cur_ext - {1'b0, delta}) : (cur_ext + {1'b0, delta});
        trained = ctl.one ? sample : moved[DATA_W-1:0];
        upd     = 1'b0;
        if (!ctl.ok) begin
            value = '0;
        end else if (ctl.load) begin
            value = sample;
        end else if (ctl.train && !ctl.none) begin
            value = trained;
            upd   = (trained != cur);
        end else begin
            value = cur;
        end
    end

endmodule
`default_nettype wire

FILE: src/som_node_neighborhood_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_node_neighborhood_update
// A request passes stages A to E and then the output register of the six-stage
// pipeline. Throughput: one request per cycle while no back-pressure or hazard
// stall holds it. A load or train to an index still in the multiply/update
// stages holds the later request in the operand stage (write-back hazard).
// Reset clears the stage and bypass valid bits; feature memory is not cleared.
// ----------------------------------------------------------------------------
module som_node_neighborhood_update (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [7:0] element_index, [39:8] sample_value, [71:40] iteration_count,
    // [79:72] winner_x, [87:80] winner_y, [95:88] node_x, [103:96] node_y
    input  wire logic [103:0]  s_tdata,
    // [1:0] command
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [31:0] element_value, [39:32] element_index_out
    output logic [39:0]        m_tdata,
    // [0] updated
    output logic [0:0]         m_tuser
);
    import snnu_pkg::*;

    // stage A: registered request
    logic              a_vld_reg;
    logic [1:0]        a_cmd_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic [DATA_W-1:0] a_smp_reg;
    logic [31:0]       a_cnt_reg;
    logic [7:0]        a_wx_reg;
    logic [7:0]        a_wy_reg;
    logic [7:0]        a_nx_reg;
    logic [7:0]        a_ny_reg;

    // stage B: operands
    logic              b_vld_reg;
    snnu_ctl_t         b_ctl_reg;
    snnu_rate_t        b_rate_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [DATA_W-1:0] b_smp_reg;

    // stage C: magnitude
    logic              c_vld_reg;
    snnu_ctl_t         c_ctl_reg;
    logic [RATE_HW-1:0] c_hi_reg;
    logic [RATE_HW-1:0] c_lo_reg;
    logic [IDX_W-1:0]  c_idx_reg;
    logic [DATA_W-1:0] c_smp_reg;
    logic [DATA_W-1:0] c_cur_reg;
    logic              c_neg_reg;
    logic [MAG_W-1:0]  c_mag_reg;

    // stage D: partial products
    logic              d_vld_reg;
    snnu_ctl_t         d_ctl_reg;
    logic [IDX_W-1:0]  d_idx_reg;
    logic [DATA_W-1:0] d_smp_reg;
    logic [DATA_W-1:0] d_cur_reg;
    logic              d_neg_reg;
    logic [PROD_W-1:0] d_phi_reg;
    logic [PROD_W-1:0] d_plo_reg;

    // stage E: delta
    logic              e_vld_reg;
    snnu_ctl_t         e_ctl_reg;
    logic [IDX_W-1:0]  e_idx_reg;
    logic [DATA_W-1:0] e_smp_reg;
    logic [DATA_W-1:0] e_cur_reg;
    logic              e_neg_reg;
    logic [MAG_W-1:0]  e_dlt_reg;

    // output register
    logic              o_vld_reg;
    logic              o_wr_reg;
    logic [IDX_W-1:0]  o_idx_reg;
    logic [DATA_W-1:0] o_val_reg;
    logic              o_upd_reg;

    logic a_vld_next, b_vld_next, c_vld_next, d_vld_next, e_vld_next, o_vld_next;
    logic o_ready, e_ready, d_ready, c_ready, b_ready, a_ready;
    logic e_adv, d_adv, c_adv, b_adv, a_adv;
    logic haz;

    snnu_rate_t        a_rate;
    snnu_ctl_t         a_ctl_next;
    logic              a_ok;
    logic [DATA_W-1:0] b_cur;
    logic [MAG_W-1:0]  b_diff;
    logic [MAG_W-1:0]  b_mag_next;
    logic [PROD_W:0]   d_sum;
    logic [DATA_W-1:0] e_val_next;
    logic              e_upd_next;
    snnu_wr_t          wr;

    // handshake chain
    always_comb begin
        o_ready  = !o_vld_reg || m_tready;
        e_adv    = e_vld_reg && o_ready;
        e_ready  = !e_vld_reg || o_ready;
        d_adv    = d_vld_reg && e_ready;
        d_ready  = !d_vld_reg || e_ready;
        c_adv    = c_vld_reg && d_ready;
        c_ready  = !c_vld_reg || d_ready;
        haz      = (c_vld_reg && c_ctl_reg.wr && c_idx_reg == b_idx_reg)
                || (d_vld_reg && d_ctl_reg.wr && d_idx_reg == b_idx_reg)
                || (e_vld_reg && e_ctl_reg.wr && e_idx_reg == b_idx_reg);
        b_adv    = b_vld_reg && !haz && c_ready;
        b_ready  = !b_vld_reg || b_adv;
        a_adv    = a_vld_reg && b_ready;
        a_ready  = !a_vld_reg || b_ready;
        s_tready = a_ready;

        a_vld_next = a_ready ? s_tvalid : a_vld_reg;
        b_vld_next = b_ready ? a_vld_reg : b_vld_reg;
        c_vld_next = c_ready ? b_adv : c_vld_reg;
        d_vld_next = d_ready ? c_vld_reg : d_vld_reg;
        e_vld_next = e_ready ? d_vld_reg : e_vld_reg;
        o_vld_next = o_ready ? e_vld_reg : o_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
            d_vld_reg <= d_vld_next;
            e_vld_reg <= e_vld_next;
            o_vld_reg <= o_vld_next;
        end
    end

    // stage A
    always_ff @(posedge aclk) begin
        if (s_tvalid && a_ready) begin
            a_cmd_reg <= s_tuser;
            a_idx_reg <= s_tdata[7:0];
            a_smp_reg <= s_tdata[39:8];
            a_cnt_reg <= s_tdata[71:40];
            a_wx_reg  <= s_tdata[79:72];
            a_wy_reg  <= s_tdata[87:80];
            a_nx_reg  <= s_tdata[95:88];
            a_ny_reg  <= s_tdata[103:96];
        end
    end

    snnu_sched u_sched (
        .iteration_count (a_cnt_reg),
        .winner_x        (a_wx_reg),
        .winner_y        (a_wy_reg),
        .node_x          (a_nx_reg),
        .node_y          (a_ny_reg),
        .rate            (a_rate)
    );

    always_comb begin
        a_ok             = (32'(a_idx_reg) < FEATURE_LEN);
        a_ctl_next.ok    = a_ok;
        a_ctl_next.load  = 1'b0;
        a_ctl_next.train = 1'b0;
        a_ctl_next.none  = a_rate.none;
        a_ctl_next.one   = a_rate.one;
        unique case (a_cmd_reg)
            CMD_LOAD:  a_ctl_next.load  = 1'b1;
            CMD_TRAIN: a_ctl_next.train = 1'b1;
            default:   a_ctl_next.load  = 1'b0;
        endcase
        a_ctl_next.wr = a_ok && (a_ctl_next.load || (a_ctl_next.train && !a_rate.none));
    end

    // stage B
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_ctl_reg  <= a_ctl_next;
            b_rate_reg <= a_rate;
            b_idx_reg  <= a_idx_reg;
            b_smp_reg  <= a_smp_reg;
        end
    end

    snnu_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (a_adv),
        .rd_idx  (a_idx_reg),
        .wr      (wr),
        .chk_idx (b_idx_reg),
        .cur     (b_cur)
    );

    always_comb begin
        b_diff     = {b_smp_reg[DATA_W-1], b_smp_reg} - {b_cur[DATA_W-1], b_cur};
        b_mag_next = b_diff[MAG_W-1] ? (MAG_W'(0) - b_diff) : b_diff;
    end

    // stage C
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            c_ctl_reg <= b_ctl_reg;
            c_hi_reg  <= b_rate_reg.hi;
            c_lo_reg  <= b_rate_reg.lo;
            c_idx_reg <= b_idx_reg;
            c_smp_reg <= b_smp_reg;
            c_cur_reg <= b_cur;
            c_neg_reg <= b_diff[MAG_W-1];
            c_mag_reg <= b_mag_next;
        end
    end

    // stage D
    always_ff @(posedge aclk) begin
        if (c_adv) begin
            d_ctl_reg <= c_ctl_reg;
            d_idx_reg <= c_idx_reg;
            d_smp_reg <= c_smp_reg;
            d_cur_reg <= c_cur_reg;
            d_neg_reg <= c_neg_reg;
            d_phi_reg <= PROD_W'(c_mag_reg) * PROD_W'(c_hi_reg);
            d_plo_reg <= PROD_W'(c_mag_reg) * PROD_W'(c_lo_reg);
        end
    end

    assign d_sum = {1'b0, d_phi_reg} + {1'b0, (d_plo_reg >> RATE_HW)};

    // stage E
    always_ff @(posedge aclk) begin
        if (d_adv) begin
            e_ctl_reg <= d_ctl_reg;
            e_idx_reg <= d_idx_reg;
            e_smp_reg <= d_smp_reg;
            e_cur_reg <= d_cur_reg;
            e_neg_reg <= d_neg_reg;
            e_dlt_reg <= d_sum[RATE_HW+MAG_W-1:RATE_HW];
        end
    end

    snnu_update u_update (
        .ctl    (e_ctl_reg),
        .neg    (e_neg_reg),
        .cur    (e_cur_reg),
        .sample (e_smp_reg),
        .delta  (e_dlt_reg),
        .value  (e_val_next),
        .upd    (e_upd_next)
    );

    always_comb begin
        wr.en   = e_adv && e_ctl_reg.wr;
        wr.idx  = e_idx_reg;
        wr.data = e_val_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (e_adv) begin
            o_wr_reg  <= e_ctl_reg.wr;
            o_idx_reg <= e_idx_reg;
            o_val_reg <= e_val_next;
            o_upd_reg <= e_upd_next;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {o_idx_reg, o_val_reg};
    assign m_tuser  = o_upd_reg;

`ifndef ASSERT_OFF
    a_ready_after_reset: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_hazard_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        b_vld_reg && haz && c_ready |=> !c_vld_reg)
        else $error("request passed operand stage during write-back hazard");

    a_update_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> o_wr_reg)
        else $error("updated flag on a request that did not write");

    a_write_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> o_vld_reg && o_wr_reg && o_idx_reg == $past(e_idx_reg))
        else $error("memory write not reflected in output register");
`endif

endmodule
`default_nettype wire

FILE: tb/som_node_neighborhood_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_node_neighborhood_update_tb
// Drives load, train and read requests into one SOM node and checks each
// result against a behavioral model of the feature vector and the
// band/distance learning-rate schedule, under random source and sink stalls.
// ----------------------------------------------------------------------------
module som_node_neighborhood_update_tb;
    import snnu_pkg::*;

    localparam int              CLK_PERIOD   = 20;
    localparam int              PIPE_LATENCY = 5;
    localparam int              CYCLE_LIMIT  = 200000;
    localparam int              MAX_REPORTS  = 10;
    localparam logic [1:0]      CMD_READ_ALT = 2'd3;    // decodes as read
    localparam longint unsigned RATE_UNITY   = 64'd1 << 40;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [31:0] sample;
        logic [31:0] count;
        logic [7:0]  wx;
        logic [7:0]  wy;
        logic [7:0]  nx;
        logic [7:0]  ny;
    } node_request_t;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  idx;
        logic        updated;
    } element_result_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = CMD_READ;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic [0:0]   m_tuser;

    logic [31:0]     feature_mem [FEATURE_LEN];
    bit              loaded [FEATURE_LEN];
    int              loaded_list [$];
    element_result_t pending_results [$];
    int              mismatches    = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_cycles   = 0;
    int              cycle_count   = 0;
    logic [7:0]      last_idx      = '0;

    som_node_neighborhood_update i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // learning rate scaled by 2^40, zero when the node is not updated
    function automatic longint unsigned learning_rate(logic [31:0] count, int distance);
        int h = MAP_SIDE;
        if (count < 32'd5000000) begin
            if (count <= 32'd1000 && 2 * distance < 3 * h) return RATE_UNITY;
            if (count <= 32'd100000 && distance < h) return 64'd549755813888;
            if (count <= 32'd1000000 && 3 * distance < 2 * h) return 64'd109951162777;
            if (count <= 32'd1500000 && distance < h / 2) return 64'd54975581388;
            if (count <= 32'd2000000 && distance < h / 3) return 64'd10995116277;
            if (count <= 32'd2500000 && distance < h / 4) return 64'd5497558138;
            if (count <= 32'd3000000 && distance < h / 5) return 64'd1099511627;
            if (count <= 32'd4000000 && distance < h / 6) return 64'd549755813;
            if (distance < h / 7) return 64'd109951162;
            return 0;
        end
        if (count < 32'd10000000) begin
            if (distance <= 3) return 64'd10995116;
            if (distance == 4) return 64'd5497558;
            if (distance == 5) return 64'd3298534;
            if (distance == 6) return 64'd1099511;
            if (distance == 7) return 64'd549755;
            if (distance == 8) return 64'd109951;
            return 0;
        end
        if (count < 32'd100000000) begin
            if (distance == 0) return 64'd109951;
            if (distance == 1) return 64'd54975;
            if (distance == 2) return 64'd10995;
            return 0;
        end
        if (distance == 0) return 64'd1099;
        if (distance == 1) return 64'd549;
        return 0;
    endfunction

    // applies one accepted request to the model vector, returns its result
    function automatic element_result_t apply_request(node_request_t r);
        element_result_t res;
        longint          cur;
        longint          nxt;
        longint          diff;
        longint          smp;
        longint unsigned rate;
        longint unsigned mag;
        logic [95:0]     prod;
        int              dx;
        int              dy;
        res = '0;
        res.idx = r.idx;
        if (int'(r.idx) < FEATURE_LEN) begin
            if (r.cmd == CMD_LOAD) begin
                feature_mem[r.idx] = r.sample;
                if (!loaded[r.idx]) begin
                    loaded[r.idx] = 1'b1;
                    loaded_list = {loaded_list, int'(r.idx)};
                end
            end else if (r.cmd == CMD_TRAIN) begin
                dx = int'(r.nx) - int'(r.wx);
                dy = int'(r.ny) - int'(r.wy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                rate = learning_rate(r.count, dx + dy);
                if (rate != 0) begin
                    cur = longint'($signed(feature_mem[r.idx]));
                    smp = longint'($signed(r.sample));
                    if (rate == RATE_UNITY) begin
                        nxt = smp;
                    end else begin
                        diff = smp - cur;
                        mag  = (diff < 0) ? -diff : diff;
                        prod = 96'(mag) * 96'(rate);
                        nxt  = (diff < 0) ? cur - longint'(prod[95:40])
                                          : cur + longint'(prod[95:40]);
                    end
                    res.updated = (nxt != cur);
                    feature_mem[r.idx] = nxt[31:0];
                end
            end
            res.value = feature_mem[r.idx];
        end
        return res;
    endfunction

    function automatic logic [7:0] offset_coord(logic [7:0] base, int off);
        return (int'(base) + off <= 255) ? 8'(int'(base) + off) : 8'(int'(base) - off);
    endfunction

    function automatic logic [31:0] random_count();
        case ($urandom_range(11))
            0:       return $urandom_range(1000);
            1:       return $urandom_range(100000, 1001);
            2:       return $urandom_range(1000000, 100001);
            3:       return $urandom_range(1500000, 1000001);
            4:       return $urandom_range(2000000, 1500001);
            5:       return $urandom_range(2500000, 2000001);
            6:       return $urandom_range(3000000, 2500001);
            7:       return $urandom_range(4000000, 3000001);
            8:       return $urandom_range(4999999, 4000001);
            9:       return $urandom_range(9999999, 5000000);
            10:      return $urandom_range(99999999, 10000000);
            default: return $urandom;
        endcase
    endfunction

    // reads and trains only touch loaded elements; a third of them reuse
    // the previous index to exercise the write-back hazard
    function automatic node_request_t random_request();
        node_request_t r;
        int            pick;
        int            d;
        int            dx;
        case ($urandom_range(9))
            0:       r.sample = 32'h8000_0000;
            1:       r.sample = 32'h7FFF_FFFF;
            default: r.sample = $urandom;
        endcase
        r.count = random_count();
        r.wx = 8'($urandom_range(255));
        r.wy = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) begin
            r.nx = 8'($urandom_range(255));
            r.ny = 8'($urandom_range(255));
        end else begin
            d  = ($urandom_range(2) == 0) ? $urandom_range(50) : $urandom_range(8);
            dx = $urandom_range(d);
            r.nx = offset_coord(r.wx, dx);
            r.ny = offset_coord(r.wy, d - dx);
        end
        pick = $urandom_range(99);
        if (loaded_list.size() == 0 || pick < 25) begin
            r.cmd = CMD_LOAD;
            r.idx = 8'($urandom_range(255));
        end else begin
            if (pick < 80) r.cmd = CMD_TRAIN;
            else if (pick < 93) r.cmd = CMD_READ;
            else r.cmd = CMD_READ_ALT;
            if (pick % 3 == 0 && loaded[last_idx]) r.idx = last_idx;
            else r.idx = 8'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        end
        last_idx = r.idx;
        return r;
    endfunction

    // entered and left at a rising edge; handshake sampled at the falling edge
    task automatic send_request(node_request_t r);
        bit granted;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {r.ny, r.nx, r.wy, r.wx, r.count, r.sample, r.idx};
        do begin
            @(negedge aclk);
            granted = s_tready;
            @(posedge aclk);
        end while (!granted);
        pending_results = {pending_results, apply_request(r)};
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d at cycle %0d: %s expected %h got %h",
                     mismatches, cycle_count, what, want, got);
    endfunction

    // field order: cmd, idx, sample, count, wx, wy, nx, ny
    task automatic test_directed_corners();
        send_idle_pct = 30;
        recv_idle_pct = 30;
        send_request({CMD_LOAD,  8'd0,   32'h7FFF_FFFF, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_request({CMD_LOAD,  8'd255, 32'h8000_0000, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_request({CMD_LOAD,  8'd1,   32'h0000_0000, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_request({CMD_LOAD,  8'd2,   32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_request({CMD_READ,  8'd0,   32'h0, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_request({CMD_READ_ALT, 8'd255, 32'h0, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        // full rate at both ends of the first band and distance range
        send_request({CMD_TRAIN, 8'd0,   32'h8000_0000, 32'd0,
                      8'd255, 8'd255, 8'd255, 8'd255});
        send_request({CMD_TRAIN, 8'd255, 32'h7FFF_FFFF, 32'd1000,
                      8'd0, 8'd0, 8'd23, 8'd24});
        // one step down the early schedule per request
        send_request({CMD_TRAIN, 8'd255, 32'h8000_0000, 32'd1001,
                      8'd0, 8'd0, 8'd31, 8'd0});
        send_request({CMD_TRAIN, 8'd0,   32'h7FFF_FFFF, 32'd100001,
                      8'd10, 8'd10, 8'd20, 8'd21});
        send_request({CMD_TRAIN, 8'd2,   32'h1234_5678, 32'd1500000,
                      8'd100, 8'd100, 8'd92, 8'd93});
        send_request({CMD_TRAIN, 8'd2,   32'h8000_0000, 32'd2000000,
                      8'd50, 8'd60, 8'd45, 8'd56});
        send_request({CMD_TRAIN, 8'd2,   32'h7FFF_FFFF, 32'd2500000,
                      8'd0, 8'd255, 8'd7, 8'd255});
        send_request({CMD_TRAIN, 8'd0,   32'h0001_0000, 32'd3000000,
                      8'd200, 8'd0, 8'd200, 8'd5});
        send_request({CMD_TRAIN, 8'd0,   32'hFFFF_0000, 32'd4000000,
                      8'd128, 8'd128, 8'd126, 8'd130});
        send_request({CMD_TRAIN, 8'd0,   32'h7FFF_FFFF, 32'd4999999,
                      8'd1, 8'd1, 8'd0, 8'd3});
        send_request({CMD_TRAIN, 8'd0,   32'h7FFF_FFFF, 32'd4999999,
                      8'd1, 8'd1, 8'd0, 8'd4});
        // late bands: edge of the distance table, then just past it
        send_request({CMD_TRAIN, 8'd255, 32'h7FFF_FFFF, 32'd5000000,
                      8'd10, 8'd10, 8'd14, 8'd14});
        send_request({CMD_TRAIN, 8'd255, 32'h7FFF_FFFF, 32'd5000000,
                      8'd10, 8'd10, 8'd14, 8'd15});
        send_request({CMD_TRAIN, 8'd255, 32'h8000_0000, 32'd10000000,
                      8'd30, 8'd30, 8'd30, 8'd30});
        send_request({CMD_TRAIN, 8'd255, 32'h7FFF_FFFF, 32'd99999999,
                      8'd30, 8'd30, 8'd31, 8'd31});
        send_request({CMD_TRAIN, 8'd255, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                      8'd255, 8'd0, 8'd254, 8'd0});
        // rate too small to move the element, and the farthest node
        send_request({CMD_TRAIN, 8'd1,   32'h0000_0001, 32'hFFFF_FFFF,
                      8'd7, 8'd7, 8'd7, 8'd7});
        send_request({CMD_TRAIN, 8'd255, 32'h7FFF_FFFF, 32'd0,
                      8'd255, 8'd255, 8'd0, 8'd0});
        send_request({CMD_READ,  8'd2,   32'h0, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        wait_results_drained();
    endtask

    task automatic test_random_traffic(int n_requests, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n_requests) send_request(random_request());
        wait_results_drained();
    endtask

    // sink stalls long enough to fill the pipeline while requests keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 80;
        repeat (40) send_request(random_request());
        wait_results_drained();
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(negedge aclk) begin
        element_result_t got;
        element_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[39:32], m_tuser[0]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                    report_mismatch("element_value", want.value, got.value);
                if (got.idx !== want.idx)
                    report_mismatch("element_index_out", want.idx, got.idx);
                if (got.updated !== want.updated)
                    report_mismatch("updated", want.updated, got.updated);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_random_traffic(230, 10, 83);
        test_random_traffic(230, 83, 10);
        test_output_backpressure();
        test_random_traffic(230, 0, 0);
        wait_results_drained();
        repeat (4 * PIPE_LATENCY) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
